// ----- hdl/rrg_pkg.sv -----
// Package with the constants and round functions of the ranged random generator.
package rrg_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;

    localparam logic [DATA_W-1:0] MIX_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [DATA_W-1:0] SHIFT_MASK  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [DATA_W-1:0] SHIFT_XOR   = 64'hB502_6F5A_A966_19E9;
    localparam logic [DATA_W-1:0] TEMPER_SEL  = 64'h0000_38EB_3FFF_F6D3;
    localparam logic [DATA_W-1:0] TEMPER_MASK = 64'hFFFF_FFFF_FFFF_BF77;

    // The mixing rounds run with index 1 through MIX_ROUNDS-1.
    localparam int unsigned MIX_ROUNDS       = 64;
    localparam int unsigned SHIFT_ROUNDS     = 312;
    localparam int unsigned SHIFTS_PER_CYCLE = 4;
    localparam int unsigned SHIFT_CYCLES     = SHIFT_ROUNDS / SHIFTS_PER_CYCLE;
    localparam int unsigned DIV_CYCLES       = DATA_W;

    localparam int unsigned CNT_W = $clog2(SHIFT_CYCLES);
    localparam int unsigned RND_W = $clog2(MIX_ROUNDS);

    // Phases of one mixing round on the shared 32x32 multiplier.
    typedef enum logic [1:0] {
        MIX_LO_LO,
        MIX_LO_HI,
        MIX_HI_LO
    } mix_phase_t;

    // One masked shift-xor round.
    function automatic logic [DATA_W-1:0] shift_round(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] t;
        t = (s ^ (s >> 1)) & SHIFT_MASK;
        return t ^ (t >> 1) ^ SHIFT_XOR;
    endfunction

    // The rounds done in one cycle of the shift phase.
    function automatic logic [DATA_W-1:0] shift_group(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] t;
        t = s;
        for (int k = 0; k < SHIFTS_PER_CYCLE; k++) begin
            t = shift_round(t);
        end
        return t;
    endfunction

    // Output tempering.
    function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] p;
        v = (s >> 29) ^ s;
        a = (v & TEMPER_SEL) << 17;
        p = ((a ^ v) & TEMPER_MASK) << 37;
        return p ^ a ^ v ^ (v >> 43);
    endfunction

endpackage

// ----- hdl/ranged_random_generator_top.sv -----
// Top level of the ranged random generator: sequencer, shared multiplier and divider.
//
//   Channel   Direction  Handshake                    Payload
//   in        request    in_valid / in_stall          lower_bound, upper_bound
//   out       result     out_valid / out_stall        random_value
//   config    write      seed_start_we                seed_start_wdata
//
// A request with lower_bound > upper_bound goes from the accepting edge straight to the
// result step. Any other request runs through the 63 mixing rounds (three passes each
// through one shared 32x32 multiplier), the 312 shift-xor rounds (four per cycle),
// tempering, the one-bit-a-cycle restoring remainder, which a full 64-bit span skips,
// and the result step.
// The block takes no new request until the current one has reached the output
// register; a result waiting under out_stall holds the sequencer in its last step.
// Reset clears the seed, the seed-loaded flag and the configuration register.
module ranged_random_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_start_we,
    input  logic [63:0] seed_start_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] lower_bound,
    input  logic [63:0] upper_bound,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_value
);

    localparam int unsigned DW = rrg_pkg::DATA_W;
    localparam int unsigned HW = rrg_pkg::HALF_W;
    localparam int unsigned CW = rrg_pkg::CNT_W;
    localparam int unsigned RW = rrg_pkg::RND_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_SHIFT,
        ST_TEMPER,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    rrg_pkg::mix_phase_t phase_reg, phase_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       seed_start_reg, seed_start_next;
    logic                seed_loaded_reg, seed_loaded_next;
    logic [DW-1:0]       seed_reg, seed_next;
    logic [DW-1:0]       mix_x_reg, mix_x_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [DW-1:0]       work_reg, work_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       lo_reg, lo_next;
    logic [DW-1:0]       span_reg, span_next;
    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       random_value_reg, random_value_next;

    logic          in_accept;
    logic [DW-1:0] mix_x;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [DW-1:0] mul_p;
    logic [DW-1:0] acc_sum;
    logic [DW:0]   trial;
    logic [DW:0]   trial_diff;
    logic [DW-1:0] tempered;
    logic [DW-1:0] span_calc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign random_value = random_value_reg;

    // The xor-fold that opens each mixing round is taken straight from the seed
    // in the first phase and kept in mix_x_reg for the other two.
    assign mix_x = seed_reg ^ (seed_reg >> 62);

    // Shared multiplier. The low 64 bits of x * MIX_MULT are
    // xl*ml + ((xl*mh + xh*ml) << 32), so only the low halves of the cross
    // products are needed.
    always_comb
    begin
        unique case (phase_reg)
            rrg_pkg::MIX_LO_LO:
            begin
                mul_a = mix_x[HW-1:0];
                mul_b = rrg_pkg::MIX_MULT[HW-1:0];
            end
            rrg_pkg::MIX_LO_HI:
            begin
                mul_a = mix_x_reg[HW-1:0];
                mul_b = rrg_pkg::MIX_MULT[DW-1:HW];
            end
            rrg_pkg::MIX_HI_LO:
            begin
                mul_a = mix_x_reg[DW-1:HW];
                mul_b = rrg_pkg::MIX_MULT[HW-1:0];
            end
            default:
            begin
                mul_a = mix_x_reg[HW-1:0];
                mul_b = rrg_pkg::MIX_MULT[HW-1:0];
            end
        endcase
    end

    assign mul_p   = DW'(mul_a) * DW'(mul_b);
    assign acc_sum = acc_reg + {mul_p[HW-1:0], {HW{1'b0}}};

    // One restoring step of the remainder: bring in the next dividend bit and
    // subtract the span if it fits.
    assign trial      = {rem_reg, work_reg[DW-1]};
    assign trial_diff = trial - {1'b0, span_reg};

    assign tempered  = rrg_pkg::temper(work_reg);
    assign span_calc = upper_bound - lower_bound + DW'(1);

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        seed_start_next   = seed_start_reg;
        seed_loaded_next  = seed_loaded_reg;
        seed_next         = seed_reg;
        mix_x_next        = mix_x_reg;
        acc_next          = acc_reg;
        work_next         = work_reg;
        rem_next          = rem_reg;
        lo_next           = lo_reg;
        span_next         = span_reg;
        out_valid_next    = out_valid_reg;
        random_value_next = random_value_reg;

        if (seed_start_we)
        begin
            seed_start_next = seed_start_wdata;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    lo_next   = lower_bound;
                    span_next = span_calc;
                    rem_next  = '0;
                    if (lower_bound > upper_bound)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (!seed_loaded_reg)
                        begin
                            seed_next        = seed_start_reg;
                            seed_loaded_next = 1'b1;
                        end
                        phase_next = rrg_pkg::MIX_LO_LO;
                        cnt_next   = CW'(1);
                        state_next = ST_MIX;
                    end
                end
            end

            ST_MIX:
            begin
                unique case (phase_reg)
                    rrg_pkg::MIX_LO_LO:
                    begin
                        mix_x_next = mix_x;
                        acc_next   = mul_p;
                        phase_next = rrg_pkg::MIX_LO_HI;
                    end
                    rrg_pkg::MIX_LO_HI:
                    begin
                        acc_next   = acc_sum;
                        phase_next = rrg_pkg::MIX_HI_LO;
                    end
                    rrg_pkg::MIX_HI_LO:
                    begin
                        seed_next  = acc_sum + DW'(cnt_reg[RW-1:0]);
                        phase_next = rrg_pkg::MIX_LO_LO;
                        if (cnt_reg == CW'(rrg_pkg::MIX_ROUNDS - 1))
                        begin
                            work_next  = acc_sum + DW'(cnt_reg[RW-1:0]);
                            cnt_next   = '0;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = rrg_pkg::MIX_LO_LO;
                    end
                endcase
            end

            ST_SHIFT:
            begin
                work_next = rrg_pkg::shift_group(work_reg);
                if (cnt_reg == CW'(rrg_pkg::SHIFT_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_TEMPER;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_TEMPER:
            begin
                // A span that wrapped to zero covers every value: no reduction.
                if (span_reg == '0)
                begin
                    rem_next   = tempered;
                    state_next = ST_DONE;
                end
                else
                begin
                    work_next  = tempered;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                if (!trial_diff[DW])
                begin
                    rem_next = trial_diff[DW-1:0];
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                end
                work_next = work_reg << 1;
                if (cnt_reg == CW'(rrg_pkg::DIV_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    random_value_next = lo_reg + rem_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= rrg_pkg::MIX_LO_LO;
            cnt_reg          <= '0;
            seed_start_reg   <= '0;
            seed_loaded_reg  <= 1'b0;
            seed_reg         <= '0;
            mix_x_reg        <= '0;
            acc_reg          <= '0;
            work_reg         <= '0;
            rem_reg          <= '0;
            lo_reg           <= '0;
            span_reg         <= '0;
            out_valid_reg    <= 1'b0;
            random_value_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            seed_start_reg   <= seed_start_next;
            seed_loaded_reg  <= seed_loaded_next;
            seed_reg         <= seed_next;
            mix_x_reg        <= mix_x_next;
            acc_reg          <= acc_next;
            work_reg         <= work_next;
            rem_reg          <= rem_next;
            lo_reg           <= lo_next;
            span_reg         <= span_next;
            out_valid_reg    <= out_valid_next;
            random_value_reg <= random_value_next;
        end
    end

    // Inverted bounds go straight to the result step.
    a_inverted_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (lower_bound > upper_bound)) |=> (state_reg == ST_DONE))
        else $error("inverted bounds did not go to the result step");

    // Once loaded, the seed stays loaded until reset.
    a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seed_loaded_reg |=> seed_loaded_reg)
        else $error("seed-loaded flag dropped");

    // The first valid request after reset picks up the configured seed.
    a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !seed_loaded_reg && (lower_bound <= upper_bound))
        |=> (seed_reg == $past(seed_start_reg)))
        else $error("seed was not loaded from the configuration register");

    // The partial remainder always stays below the span.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < span_reg))
        else $error("partial remainder reached the span");

    // A new result only appears out of the result step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown outside the result step");

endmodule

// ----- tb/ranged_random_generator_top_tb.sv -----
// Self-checking testbench for the ranged random generator: directed rows, then random requests.
`timescale 1ns / 100ps

module ranged_random_generator_top_tb;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Mixing and tempering constants, kept here so that the prediction does not lean on
    // the package it is meant to check.
    localparam logic [63:0] STIR_MULT     = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] SCRAMBLE_MASK = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] SCRAMBLE_XOR  = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TEMPER_PICK   = 64'h0000_38EB_3FFF_F6D3;
    localparam logic [63:0] TEMPER_KEEP   = 64'hFFFF_FFFF_FFFF_BF77;
    localparam int unsigned STIR_ROUNDS     = 64;
    localparam int unsigned SCRAMBLE_ROUNDS = 312;

    // The rows before N_PRELOAD have inverted bounds, so they run before any seed is loaded.
    localparam int unsigned N_PRELOAD  = 3;
    localparam int unsigned N_DIRECTED = 18;
    localparam int unsigned N_RANDOM   = 1082;
    localparam int unsigned MAX_IDLE   = 17;
    localparam int unsigned MAX_PRINTS = 40;
    // The quiet time allowed at the end, longer than a correct request takes.
    localparam int unsigned TAIL_CYCLES = 400;

    // One directed row. When fixed is set, value is the result that can be read off the
    // bounds alone; otherwise the predictor supplies it.
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        fixed;
        logic [63:0] value;
    } stim_row_t;

    // One request waiting for its result.
    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] value;
    } draw_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_start_we = 1'b0;
    logic [63:0] seed_start_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] lower_bound = '0;
    logic [63:0] upper_bound = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] random_value;

    // Predictor state: the seed register, the running seed and the loaded flag.
    logic [63:0] seed_reg_q = '0;
    logic [63:0] run_seed_q = '0;
    bit          seed_taken_q = 1'b0;

    draw_expect_t expected_values[$];
    draw_expect_t head;

    int unsigned error_count = 0;
    int unsigned request_count = 0;
    int unsigned inverted_count = 0;
    int unsigned equal_count = 0;
    int unsigned full_span_count = 0;
    int unsigned checked_count = 0;
    int unsigned seed_writes = 0;
    int unsigned stall_left = 0;
    bit          steady_flow = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // Inverted bounds before the seed is loaded: the lower bound comes straight back.
        '{ALL_ONES, 64'd0, 1'b1, ALL_ONES},
        '{64'd1, 64'd0, 1'b1, 64'd1},
        '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000},
        // The first proper request loads the seed; equal bounds still advance it.
        '{64'd0, 64'd0, 1'b1, 64'd0},
        '{64'd0, ALL_ONES, 1'b0, 64'd0},
        '{ALL_ONES, ALL_ONES, 1'b1, ALL_ONES},
        '{64'd0, 64'd1, 1'b0, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFFE, ALL_ONES, 1'b0, 64'd0},
        '{64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{64'd0, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
        '{64'd1, ALL_ONES, 1'b0, 64'd0},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
        '{64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 1'b1, 64'h1234_5678_9ABC_DEF0},
        '{64'd100, 64'd199, 1'b0, 64'd0},
        '{64'd0, ALL_ONES, 1'b0, 64'd0},
        '{64'hFFFF_FFFF_0000_0000, ALL_ONES, 1'b0, 64'd0},
        '{ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, ALL_ONES}
    };

    ranged_random_generator_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .seed_start_we   (seed_start_we),
        .seed_start_wdata(seed_start_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lower_bound     (lower_bound),
        .upper_bound     (upper_bound),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .random_value    (random_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run must never take this long; forty million ns is several times the slowest
    // correct run with every gap and stall at its longest.
    initial
    begin
        #40_000_000;
        $display("ranged_random_generator_top_tb NOT OK");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle or stall length for one request. While steady_flow is set, both sides run
    // back to back so that the block also sees stretches without any gaps.
    function automatic int unsigned wait_cycles();
        if (steady_flow)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Multiply-add rounds that move the running seed forward.
    function automatic logic [63:0] stir_seed(input logic [63:0] s);
        logic [63:0] t;
        t = s;
        for (int unsigned i = 1; i < STIR_ROUNDS; i++)
        begin
            t = 64'(i) + STIR_MULT * ((t >> 62) ^ t);
        end
        return t;
    endfunction

    // Masked shift-xor rounds applied to a working copy of the seed.
    function automatic logic [63:0] scramble_rounds(input logic [63:0] s);
        logic [63:0] t;
        t = s;
        for (int unsigned i = 0; i < SCRAMBLE_ROUNDS; i++)
        begin
            t = (t ^ (t >> 1)) & SCRAMBLE_MASK;
            t = t ^ (t >> 1) ^ SCRAMBLE_XOR;
        end
        return t;
    endfunction

    function automatic logic [63:0] temper_word(input logic [63:0] s);
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] p;
        v = (s >> 29) ^ s;
        a = (v & TEMPER_PICK) << 17;
        p = ((a ^ v) & TEMPER_KEEP) << 37;
        return p ^ a ^ v ^ (v >> 43);
    endfunction

    // Result of one accepted request, advancing the predictor state as the block would.
    // Inverted bounds return the lower bound and leave the seed and the loaded flag alone.
    // A span that wraps to zero means the full 64-bit range, so no reduction is done.
    function automatic logic [63:0] predict_value(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] tempered;
        logic [63:0] span;
        if (lo > hi)
            return lo;
        if (!seed_taken_q)
        begin
            run_seed_q = seed_reg_q;
            seed_taken_q = 1'b1;
        end
        run_seed_q = stir_seed(run_seed_q);
        tempered = temper_word(scramble_rounds(run_seed_q));
        span = hi - lo + 64'd1;
        if (span == 64'd0)
            return lo + tempered;
        return lo + tempered % span;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Writes the seed register. The block must be idle; a write after the seed was
    // loaded is kept in the register but has no effect, and the next reset clears it.
    task automatic write_seed(input logic [63:0] value);
        seed_start_we <= 1'b1;
        seed_start_wdata <= value;
        @(posedge clk);
        seed_start_we <= 1'b0;
        seed_reg_q = value;
        seed_writes++;
    endtask

    // Stops sending and waits until every request has returned its result, then waits on
    // so that the block has left its output step before the register changes.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offers one request after a random gap and holds it until the block takes it. The
    // expectation is queued at the edge of acceptance, in the order the block sees it.
    task automatic send_request(input logic [63:0] lo, input logic [63:0] hi,
                                input logic fixed, input logic [63:0] fixed_value);
        int unsigned  gap;
        logic [63:0]  predicted;
        draw_expect_t entry;
        gap = wait_cycles();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        lower_bound <= lo;
        upper_bound <= hi;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = predict_value(lo, hi);
        entry.lo = lo;
        entry.hi = hi;
        entry.value = fixed ? fixed_value : predicted;
        expected_values.push_back(entry);
        request_count++;
        if (lo > hi)
            inverted_count++;
        else if (lo == hi)
            equal_count++;
        else if (lo == 64'd0 && hi == ALL_ONES)
            full_span_count++;
    endtask

    // Random bounds, weighted toward the shapes that exercise the reduction: inverted
    // pairs, equal bounds, the full span, narrow spans, spans from zero and spans of a
    // power of two. A last kind takes a shifted raw value and a raw one in whichever order they come.
    task automatic pick_bounds(output logic [63:0] lo, output logic [63:0] hi);
        int unsigned kind;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] span;
        kind = $urandom_range(0, 99);
        a = rand64();
        b = rand64();
        if (kind < 10)
        begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end
        else if (kind < 15)
        begin
            lo = a;
            hi = a;
        end
        else if (kind < 20)
        begin
            lo = 64'd0;
            hi = ALL_ONES;
        end
        else if (kind < 45)
        begin
            span = 64'($urandom_range(0, 1000));
            lo = a;
            hi = a + span;
            if (hi < lo)
                hi = ALL_ONES;
        end
        else if (kind < 60)
        begin
            lo = 64'd0;
            hi = b >> $urandom_range(0, 63);
        end
        else if (kind < 75)
        begin
            span = (64'd1 << $urandom_range(1, 63)) - 64'd1;
            lo = a >> $urandom_range(0, 63);
            hi = lo + span;
            if (hi < lo)
                hi = ALL_ONES;
        end
        else
        begin
            lo = a >> $urandom_range(0, 63);
            hi = b;
        end
    endtask

    // Result side. Each accepted result is checked against the oldest pending request.
    // After every result a new stall length is drawn. The stall counts down on every
    // cycle that a result is waiting and, otherwise, at random with a chance of one in four,
    // so stalls land both on waiting results and on the long stretches while the block is busy.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no request pending",
                                              random_value));
                end
                else
                begin
                    head = expected_values.pop_front();
                    checked_count++;
                    if (random_value !== head.value)
                        report_mismatch($sformatf(
                            "bounds %h..%h: random_value %h, expected %h",
                            head.lo, head.hi, random_value, head.value));
                end
                stall_left = wait_cycles();
                out_stall <= (stall_left != 0);
            end
            else if (stall_left != 0 && (out_valid === 1'b1 || $urandom_range(0, 3) == 0))
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Request side. The seed register goes through zero and all ones before the seed is
    // loaded; only the all-ones value reaches the generator, since the requests before
    // it all have inverted bounds. Later writes, random and zero again, must be ignored.
    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_seed(64'd0);

        for (int unsigned r = 0; r < N_DIRECTED; r++)
        begin
            if (r == N_PRELOAD)
            begin
                settle();
                write_seed(ALL_ONES);
            end
            send_request(directed_rows[r].lo, directed_rows[r].hi,
                         directed_rows[r].fixed, directed_rows[r].value);
        end

        settle();
        write_seed(rand64());
        for (int unsigned r = 0; r < N_RANDOM; r++)
        begin
            if (r == N_RANDOM / 2)
            begin
                settle();
                write_seed(64'd0);
            end
            if ($urandom_range(0, 39) == 0)
                steady_flow = !steady_flow;
            pick_bounds(lo, hi);
            send_request(lo, hi, 1'b0, 64'd0);
        end

        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        // Any stray result would show up within one more request time.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d inverted, %0d equal bounds, %0d full span), %0d checked.",
                 request_count, inverted_count, equal_count, full_span_count, checked_count);
        $display("Seed register written %0d times, %0d mismatches found.",
                 seed_writes, error_count);
        if (error_count == 0)
            $display("ranged_random_generator_top_tb OK");
        else
            $display("ranged_random_generator_top_tb NOT OK");
        $finish;
    end

endmodule
